[hw/rtl/range_scan_to_points_top_macros.svh]
// assertion helpers shared by the range scan rtl
`ifndef RANGE_SCAN_TO_POINTS_TOP_MACROS_SVH
`define RANGE_SCAN_TO_POINTS_TOP_MACROS_SVH
`ifndef SYNTH
// clocked check, switched off while reset is low
`define RSTP_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked check that also holds through reset
`define RSTP_ASSERT_ANY(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RSTP_ASSERT(lbl, clk, rst_n, prop, msg)
`define RSTP_ASSERT_ANY(lbl, clk, prop, msg)
`endif
`endif

[hw/rtl/rstp_pkg.sv]
package rstp_pkg;

	// default field widths
	localparam int DIST_BITS_DEF  = 20;
	localparam int PHASE_BITS_DEF = 16;
	localparam int ANGLE_W        = 16;
	localparam int CFG_ADDR_W     = 2;

	// register indexes
	localparam logic [CFG_ADDR_W-1:0] REG_ANGLE_START = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_ANGLE_STEP  = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_MIN_RANGE   = 2'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_MAX_RANGE   = 2'd3;

	// quadrant codes of the reduced angle
	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;
	localparam logic [1:0] QUAD_3 = 2'd3;

	// fixed point trig formats
	localparam int TURN_W = 32;
	localparam int Q30_W  = 30;
	localparam int T_W    = 31;
	localparam logic [T_W-1:0] Q30_ONE = 31'h4000_0000;
	localparam logic [Q30_W-1:0] OCT_HALF = 30'h2000_0000;
	localparam logic [TURN_W-1:0] OCT_OFFSET = 32'h2000_0000;
	// fractional part of pi/2 in q32, integer part is one
	localparam logic [31:0] HALF_PI_FRAC = 32'd2451551556;

	// horner chain, one cell per step, sine lane idle in the last cell
	localparam int N_CELLS   = 5;
	localparam int SIN_STEPS = 4;
	localparam int unsigned SIN_DIVS [N_CELLS] = '{72, 42, 20, 6, 1};
	localparam int unsigned COS_DIVS [N_CELLS] = '{90, 56, 30, 12, 2};

	// one beam moving through the trig chain
	typedef struct packed {
		logic [1:0]       quad;
		logic             rneg;
		logic             kept;
		logic [Q30_W-1:0] ang;
		logic [Q30_W-1:0] x2;
		logic [T_W-1:0]   t_sin;
		logic [T_W-1:0]   t_cos;
	} beam_t;

endpackage

[hw/rtl/rstp_front.sv]
module rstp_front
	import rstp_pkg::*;
#(
	parameter int DIST_BITS  = DIST_BITS_DEF,
	parameter int PHASE_BITS = PHASE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [((DIST_BITS > ANGLE_W) ? DIST_BITS : ANGLE_W)-1:0] cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [DIST_BITS-1:0]  distance,
	input  logic                  first_of_scan,
	output logic                  out_valid,
	input  logic                  out_ready,
	output beam_t                 out_beam,
	output logic [DIST_BITS-1:0]  out_dist
);

	logic [PHASE_BITS-1:0] start_q, step_q, phase_q;
	logic [DIST_BITS-1:0]  min_q, max_q;
	logic [PHASE_BITS-1:0] ph;
	logic [TURN_W-1:0]     v;
	logic [Q30_W-1:0]      absr;
	logic                  gate;

	logic                  v_s1, v_s2, v_s3;
	logic                  rdy1, rdy2, rdy3;
	logic [Q30_W-1:0]      absr_s1;
	logic [1:0]            quad_s1, quad_s2;
	logic                  rneg_s1, rneg_s2, kept_s1, kept_s2;
	logic [DIST_BITS-1:0]  dist_s1, dist_s2, dist_s3;
	logic [Q30_W-1:0]      ang_s2;
	beam_t                 beam_s3;

	logic [61:0]           frac_prod;
	logic [Q30_W-1:0]      ang;
	logic [59:0]           sq_prod;
	beam_t                 beam_nx;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			step_q  <= '0;
			min_q   <= '0;
			max_q   <= '1;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_ANGLE_START: start_q <= PHASE_BITS'({{(TURN_W-ANGLE_W){cfg_wdata[ANGLE_W-1]}},
					cfg_wdata[ANGLE_W-1:0]});
				REG_ANGLE_STEP: step_q <= PHASE_BITS'({{(TURN_W-ANGLE_W){cfg_wdata[ANGLE_W-1]}},
					cfg_wdata[ANGLE_W-1:0]});
				REG_MIN_RANGE: min_q <= DIST_BITS'(cfg_wdata);
				REG_MAX_RANGE: max_q <= DIST_BITS'(cfg_wdata);
				default: ;
			endcase
		end
	end

	// stall chain
	assign rdy3     = !v_s3 || out_ready;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	// beam phase, reloaded on the first sample of a scan
	assign ph = first_of_scan ? start_q : phase_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (in_valid && rdy1) begin
			phase_q <= ph + step_q;
		end
	end

	// octant centred residual and quadrant
	assign v    = {ph, {(TURN_W-PHASE_BITS){1'b0}}} + OCT_OFFSET;
	assign absr = v[29] ? {1'b0, v[28:0]} : (OCT_HALF - {1'b0, v[28:0]});
	assign gate = (distance > min_q) && (distance < max_q);

	// stage 1: range gate and angle reduction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			absr_s1 <= absr;
			quad_s1 <= v[31:30];
			rneg_s1 <= !v[29];
			kept_s1 <= gate;
			dist_s1 <= distance;
		end
	end

	// stage 2: residual to radians in q30
	assign frac_prod = 62'(absr_s1) * 62'(HALF_PI_FRAC);
	assign ang       = absr_s1 + Q30_W'((frac_prod + 62'h8000_0000) >> 32);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2) begin
			ang_s2  <= ang;
			quad_s2 <= quad_s1;
			rneg_s2 <= rneg_s1;
			kept_s2 <= kept_s1;
			dist_s2 <= dist_s1;
		end
	end

	// stage 3: squared angle, horner terms start at one
	assign sq_prod = 60'(ang_s2) * 60'(ang_s2);

	always_comb begin
		beam_nx       = '0;
		beam_nx.quad  = quad_s2;
		beam_nx.rneg  = rneg_s2;
		beam_nx.kept  = kept_s2;
		beam_nx.ang   = ang_s2;
		beam_nx.x2    = Q30_W'((sq_prod + 60'h2000_0000) >> 30);
		beam_nx.t_sin = Q30_ONE;
		beam_nx.t_cos = Q30_ONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3) begin
			beam_s3 <= beam_nx;
			dist_s3 <= dist_s2;
		end
	end

	assign out_valid = v_s3;
	assign out_beam  = beam_s3;
	assign out_dist  = dist_s3;

endmodule

[hw/rtl/rstp_cell.sv]
`include "range_scan_to_points_top_macros.svh"

module rstp_cell
	import rstp_pkg::*;
#(
	parameter int          DIST_BITS = DIST_BITS_DEF,
	parameter int unsigned SIN_DIV   = 72,
	parameter int unsigned COS_DIV   = 90,
	parameter bit          SIN_EN    = 1'b1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  beam_t                in_beam,
	input  logic [DIST_BITS-1:0] in_dist,
	output logic                 out_valid,
	input  logic                 out_ready,
	output beam_t                out_beam,
	output logic [DIST_BITS-1:0] out_dist
);

	// reciprocals for exact truncating division of a 30 bit value
	localparam int          SIN_K   = Q30_W + $clog2(SIN_DIV);
	localparam int          COS_K   = Q30_W + $clog2(COS_DIV);
	localparam logic [63:0] SIN_M64 = ((64'd1 << SIN_K) + 64'(SIN_DIV) - 64'd1) / 64'(SIN_DIV);
	localparam logic [63:0] COS_M64 = ((64'd1 << COS_K) + 64'(COS_DIV) - 64'd1) / 64'(COS_DIV);
	localparam logic [31:0] SIN_M   = SIN_M64[31:0];
	localparam logic [31:0] COS_M   = COS_M64[31:0];

	logic                 v_s1, v_s2, rdy1, rdy2;
	logic [60:0]          ps_prod, pc_prod;
	logic [Q30_W-1:0]     ps_s1, pc_s1;
	beam_t                beam_s1, beam_s2, beam_nx;
	logic [DIST_BITS-1:0] dist_s1, dist_s2;
	logic [61:0]          qs_prod, qc_prod;
	logic [Q30_W-1:0]     qs, qc;

	// stall chain
	assign rdy2     = !v_s2 || out_ready;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	// stage 1: x2 times the running term
	assign ps_prod = 61'(in_beam.x2) * 61'(in_beam.t_sin);
	assign pc_prod = 61'(in_beam.x2) * 61'(in_beam.t_cos);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			ps_s1   <= ps_prod[59:30];
			pc_s1   <= pc_prod[59:30];
			beam_s1 <= in_beam;
			dist_s1 <= in_dist;
		end
	end

	// stage 2: divide by the step constant, subtract from one
	assign qs_prod = 62'(ps_s1) * 62'(SIN_M);
	assign qc_prod = 62'(pc_s1) * 62'(COS_M);
	assign qs      = Q30_W'(qs_prod >> SIN_K);
	assign qc      = Q30_W'(qc_prod >> COS_K);

	always_comb begin
		beam_nx       = beam_s1;
		beam_nx.t_cos = Q30_ONE - {1'b0, qc};
		if (SIN_EN) begin
			beam_nx.t_sin = Q30_ONE - {1'b0, qs};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2) begin
			beam_s2 <= beam_nx;
			dist_s2 <= dist_s1;
		end
	end

	assign out_valid = v_s2;
	assign out_beam  = beam_s2;
	assign out_dist  = dist_s2;

	// horner terms stay within one
	`RSTP_ASSERT(a_term_range, clk, arst_n, out_valid |-> (out_beam.t_sin <= Q30_ONE && out_beam.t_cos <= Q30_ONE), "horner term above one")

endmodule

[hw/rtl/rstp_back.sv]
module rstp_back
	import rstp_pkg::*;
#(
	parameter int DIST_BITS = DIST_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  beam_t                       in_beam,
	input  logic [DIST_BITS-1:0]        in_dist,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [DIST_BITS:0]   point_x,
	output logic signed [DIST_BITS:0]   point_y,
	output logic                        point_kept
);

	localparam int PW = DIST_BITS + T_W;

	logic                     v_s1, v_s2, v_s3, rdy1, rdy2, rdy3;
	logic [60:0]              s_prod;
	logic [Q30_W-1:0]         s_s1;
	logic [T_W-1:0]           c_s1;
	logic [1:0]               quad_s1;
	logic                     rneg_s1, kept_s1, kept_s2;
	logic [DIST_BITS-1:0]     dist_s1;
	logic [T_W-1:0]           cm, sm;
	logic                     cneg, sneg, cneg_s2, sneg_s2;
	logic [PW-1:0]            px_s2, py_s2;
	logic [PW:0]              sum_x, sum_y;
	logic [DIST_BITS+1:0]     mag_x, mag_y;
	logic [DIST_BITS-1:0]     cl_x, cl_y;
	logic signed [DIST_BITS:0] x_nx, y_nx, x_s3, y_s3;
	logic                     kept_s3;

	// stall chain
	assign rdy3     = !v_s3 || out_ready;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	// stage 1: sine is the angle times the last term
	assign s_prod = 61'(in_beam.ang) * 61'(in_beam.t_sin);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			s_s1    <= s_prod[59:30];
			c_s1    <= in_beam.t_cos;
			quad_s1 <= in_beam.quad;
			rneg_s1 <= in_beam.rneg;
			kept_s1 <= in_beam.kept;
			dist_s1 <= in_dist;
		end
	end

	// quadrant swap and signs
	always_comb begin
		unique case (quad_s1)
			QUAD_0: begin
				cm = c_s1; cneg = 1'b0; sm = {1'b0, s_s1}; sneg = rneg_s1;
			end
			QUAD_1: begin
				cm = {1'b0, s_s1}; cneg = !rneg_s1; sm = c_s1; sneg = 1'b0;
			end
			QUAD_2: begin
				cm = c_s1; cneg = 1'b1; sm = {1'b0, s_s1}; sneg = !rneg_s1;
			end
			QUAD_3: begin
				cm = {1'b0, s_s1}; cneg = rneg_s1; sm = c_s1; sneg = 1'b1;
			end
			default: begin
				cm = c_s1; cneg = 1'b0; sm = {1'b0, s_s1}; sneg = 1'b0;
			end
		endcase
	end

	// stage 2: distance times trig magnitude
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2) begin
			px_s2   <= PW'(dist_s1) * PW'(cm);
			py_s2   <= PW'(dist_s1) * PW'(sm);
			cneg_s2 <= cneg;
			sneg_s2 <= sneg;
			kept_s2 <= kept_s1;
		end
	end

	// round half away from zero, clamp, sign, zero when dropped
	assign sum_x = {1'b0, px_s2} + (PW+1)'(32'h2000_0000);
	assign sum_y = {1'b0, py_s2} + (PW+1)'(32'h2000_0000);
	assign mag_x = sum_x[PW:30];
	assign mag_y = sum_y[PW:30];
	assign cl_x  = (|mag_x[DIST_BITS+1:DIST_BITS]) ? '1 : mag_x[DIST_BITS-1:0];
	assign cl_y  = (|mag_y[DIST_BITS+1:DIST_BITS]) ? '1 : mag_y[DIST_BITS-1:0];

	always_comb begin
		x_nx = cneg_s2 ? -$signed({1'b0, cl_x}) : $signed({1'b0, cl_x});
		y_nx = sneg_s2 ? -$signed({1'b0, cl_y}) : $signed({1'b0, cl_y});
		if (!kept_s2) begin
			x_nx = '0;
			y_nx = '0;
		end
	end

	// stage 3: output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3) begin
			x_s3    <= x_nx;
			y_s3    <= y_nx;
			kept_s3 <= kept_s2;
		end
	end

	assign out_valid  = v_s3;
	assign point_x    = x_s3;
	assign point_y    = y_s3;
	assign point_kept = kept_s3;

endmodule

[hw/rtl/range_scan_to_points_top.sv]
// Range scan to Cartesian points.
// Input channel (in_valid / in_ready): one range sample per transfer, distance in
// 1/4096 m and first_of_scan, which reloads the beam phase from angle_start.
// Output channel (out_valid / out_ready): one point per sample, in order, with
// point_x = d*cos, point_y = d*sin rounded to nearest, and point_kept. A sample
// outside the open window (min_range, max_range) gives zero coordinates and
// point_kept low; the phase advances by angle_step after every sample either way.
// Config port: cfg_we writes cfg_wdata into register cfg_addr (0 angle_start,
// 1 angle_step, 2 min_range, 3 max_range); write only while idle.
// Depth: 16 register stages from input to output. Throughput: one sample per
// cycle while out_ready is high; no stage holds more than one multiplier per lane,
// and the horner chain is a row of five cells of two stages each.
// Stalls: every stage has its own valid bit; when out_ready is low the point
// waits in the output register while earlier stages keep filling empty slots,
// and in_ready drops only once every stage is occupied.
// Reset: clears all valid bits, the beam phase, both angle registers and
// min_range, and sets max_range to all ones.
`include "range_scan_to_points_top_macros.svh"

module range_scan_to_points_top
	import rstp_pkg::*;
#(
	parameter int DIST_BITS  = DIST_BITS_DEF,
	parameter int PHASE_BITS = PHASE_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [CFG_ADDR_W-1:0]       cfg_addr,
	input  logic [((DIST_BITS > ANGLE_W) ? DIST_BITS : ANGLE_W)-1:0] cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [DIST_BITS-1:0]        distance,
	input  logic                        first_of_scan,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [DIST_BITS:0]   point_x,
	output logic signed [DIST_BITS:0]   point_y,
	output logic                        point_kept
);

	logic                 valid_c [N_CELLS+1];
	logic                 ready_c [N_CELLS+1];
	beam_t                beam_c  [N_CELLS+1];
	logic [DIST_BITS-1:0] dist_c  [N_CELLS+1];

	// phase, range gate and angle reduction
	rstp_front #(
		.DIST_BITS (DIST_BITS),
		.PHASE_BITS(PHASE_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.distance     (distance),
		.first_of_scan(first_of_scan),
		.out_valid    (valid_c[0]),
		.out_ready    (ready_c[0]),
		.out_beam     (beam_c[0]),
		.out_dist     (dist_c[0])
	);

	// horner chain for sine and cosine
	for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
		rstp_cell #(
			.DIST_BITS(DIST_BITS),
			.SIN_DIV  (SIN_DIVS[i]),
			.COS_DIV  (COS_DIVS[i]),
			.SIN_EN   (i < SIN_STEPS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (valid_c[i]),
			.in_ready (ready_c[i]),
			.in_beam  (beam_c[i]),
			.in_dist  (dist_c[i]),
			.out_valid(valid_c[i+1]),
			.out_ready(ready_c[i+1]),
			.out_beam (beam_c[i+1]),
			.out_dist (dist_c[i+1])
		);
	end

	// scaling, rounding and output register
	rstp_back #(
		.DIST_BITS(DIST_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_c[N_CELLS]),
		.in_ready  (ready_c[N_CELLS]),
		.in_beam   (beam_c[N_CELLS]),
		.in_dist   (dist_c[N_CELLS]),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.point_x   (point_x),
		.point_y   (point_y),
		.point_kept(point_kept)
	);

	`RSTP_ASSERT(a_drop_zero, clk, arst_n, (out_valid && !point_kept) |-> (point_x == '0 && point_y == '0), "dropped sample with nonzero point")
	`RSTP_ASSERT_ANY(a_reset_empty, clk, !arst_n |=> !out_valid, "point shown after reset")
	`RSTP_ASSERT_ANY(a_ready_chain, clk, out_ready |-> in_ready, "input stalled while output drains")

endmodule

[dv/range_scan_to_points_top_tb.sv]
`timescale 1ns / 100ps

module range_scan_to_points_top_tb;
	import rstp_pkg::*;

	localparam int DW = DIST_BITS_DEF;
	localparam int PW = PHASE_BITS_DEF;
	localparam logic [DW-1:0] DIST_MAX = '1;
	localparam longint unsigned ONE_Q30 = 64'd1 << 30;
	localparam longint unsigned HALF_PI_Q32 = 64'd6746518852;
	localparam int PHASES = 10;
	localparam int PER_PHASE = 163;
	localparam int HOLD_CYCLES = 80;

	// one output point as the block presents it
	typedef struct packed {
		logic [DW:0] x;
		logic [DW:0] y;
		logic        kept;
	} point_t;

	// tracks beam phase and registers, queues predicted points, checks the output
	class scan_point_checker;
		logic [PW-1:0] angle_start;
		logic [PW-1:0] angle_step;
		logic [PW-1:0] beam_phase;
		logic [DW-1:0] min_range;
		logic [DW-1:0] max_range;
		point_t expected_points[$];
		int unsigned failures;

		function new();
			angle_start = '0;
			angle_step = '0;
			beam_phase = '0;
			min_range = '0;
			max_range = DIST_MAX;
			failures = 0;
		endfunction

		function void set_reg(logic [CFG_ADDR_W-1:0] addr, logic [DW-1:0] data);
			case (addr)
				REG_ANGLE_START: angle_start = data[ANGLE_W-1:0];
				REG_ANGLE_STEP:  angle_step = data[ANGLE_W-1:0];
				REG_MIN_RANGE:   min_range = data;
				REG_MAX_RANGE:   max_range = data;
				default: ;
			endcase
		endfunction

		// truncated horner step in q30
		function longint unsigned horner(longint unsigned sq, longint unsigned t,
				longint unsigned div);
			return ONE_Q30 - ((sq * t) >> 30) / div;
		endfunction

		// |d*m| / 2^30 rounded half away from zero, then signed
		function logic [DW:0] scale_coord(logic [DW-1:0] d, longint unsigned m, bit neg);
			longint unsigned dd;
			longint unsigned mag;
			dd = d;
			mag = (dd * m + (64'd1 << 29)) >> 30;
			if (mag > DIST_MAX)
				mag = DIST_MAX;
			if (neg)
				mag = -mag;
			return mag[DW:0];
		endfunction

		// range gate plus fixed point polar to cartesian
		function point_t project_beam(logic [DW-1:0] d, logic [PW-1:0] ph);
			point_t p;
			logic [31:0] turn;
			logic [1:0] quad;
			longint resid;
			longint unsigned ang, sq, ts, tc, s, c, cm, sm;
			bit rneg, cneg, sneg;
			p = '0;
			if (!(d > min_range && d < max_range))
				return p;
			turn = {ph, {(32-PW){1'b0}}};
			turn = turn + OCT_OFFSET;
			quad = turn[31:30];
			resid = turn[29:0];
			resid = resid - OCT_HALF;
			rneg = resid < 0;
			ang = rneg ? -resid : resid;
			ang = (ang * HALF_PI_Q32 + (64'd1 << 31)) >> 32;
			sq = (ang * ang + (64'd1 << 29)) >> 30;
			// sine chain
			ts = ONE_Q30 - sq / 72;
			ts = horner(sq, ts, 42);
			ts = horner(sq, ts, 20);
			ts = horner(sq, ts, 6);
			s = (ang * ts) >> 30;
			// cosine chain
			tc = ONE_Q30 - sq / 90;
			tc = horner(sq, tc, 56);
			tc = horner(sq, tc, 30);
			tc = horner(sq, tc, 12);
			c = horner(sq, tc, 2);
			// quadrant swap and sign
			case (quad)
				QUAD_0: begin
					cm = c; cneg = 1'b0; sm = s; sneg = rneg;
				end
				QUAD_1: begin
					cm = s; cneg = !rneg; sm = c; sneg = 1'b0;
				end
				QUAD_2: begin
					cm = c; cneg = 1'b1; sm = s; sneg = !rneg;
				end
				default: begin
					cm = s; cneg = rneg; sm = c; sneg = 1'b1;
				end
			endcase
			p.x = scale_coord(d, cm, cneg && cm != 0);
			p.y = scale_coord(d, sm, sneg && sm != 0);
			p.kept = 1'b1;
			return p;
		endfunction

		// input transfer: reload or advance the phase, queue the point
		function void note_beam(logic [DW-1:0] d, logic first);
			logic [PW-1:0] ph;
			if (first)
				beam_phase = angle_start;
			ph = beam_phase;
			beam_phase = beam_phase + angle_step;
			expected_points.push_back(project_beam(d, ph));
		endfunction

		// output transfer: compare against the oldest queued point
		function void check_point(logic [DW:0] x, logic [DW:0] y, logic kept);
			point_t want;
			if (expected_points.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("unexpected point x=%0d y=%0d kept=%0b", $signed(x), $signed(y),
						kept);
				return;
			end
			want = expected_points.pop_front();
			if (x !== want.x || y !== want.y || kept !== want.kept) begin
				failures++;
				if (failures <= 10)
					$display("point mismatch: exp x=%0d y=%0d kept=%0b, got x=%0d y=%0d kept=%0b",
						$signed(want.x), $signed(want.y), want.kept,
						$signed(x), $signed(y), kept);
			end
		endfunction

		function int unsigned pending();
			return expected_points.size();
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [DW-1:0]     cfg_wdata = '0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [DW-1:0]     distance = '0;
	logic              first_of_scan = 1'b0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic signed [DW:0] point_x;
	logic signed [DW:0] point_y;
	logic              point_kept;

	scan_point_checker sb;
	bit tx_idle_on = 1'b0;
	bit rx_idle_on = 1'b0;
	bit rx_hold_req = 1'b0;
	int rx_wait = 0;

	range_scan_to_points_top DUT (
		.clk,
		.arst_n,
		.cfg_we,
		.cfg_addr,
		.cfg_wdata,
		.in_valid,
		.in_ready,
		.distance,
		.first_of_scan,
		.out_valid,
		.out_ready,
		.point_x,
		.point_y,
		.point_kept
	);

	always #4 clk = ~clk;

	// receiver: long hold on request, random stall bursts, else ready
	always @(posedge clk) begin
		if (rx_hold_req) begin
			rx_hold_req = 1'b0;
			rx_wait = HOLD_CYCLES;
		end
		if (rx_wait > 0) begin
			out_ready <= 1'b0;
			rx_wait--;
		end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
			out_ready <= 1'b0;
			rx_wait = $urandom_range(0, 4);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// note input transfers before checking output transfers of the same edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_beam(distance, first_of_scan);
			if (out_valid && out_ready)
				sb.check_point(point_x, point_y, point_kept);
		end
	end

	// all four registers, one per cycle
	task automatic write_regs(logic [DW-1:0] start, logic [DW-1:0] step,
			logic [DW-1:0] lo, logic [DW-1:0] hi);
		logic [CFG_ADDR_W-1:0] idx [4];
		logic [DW-1:0] val [4];
		idx = '{REG_ANGLE_START, REG_ANGLE_STEP, REG_MIN_RANGE, REG_MAX_RANGE};
		val = '{start, step, lo, hi};
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_addr <= idx[i];
			cfg_wdata <= val[i];
			@(posedge clk);
			sb.set_reg(idx[i], val[i]);
		end
		cfg_we <= 1'b0;
	endtask

	// hold one beam until its transfer
	task automatic send_beam(logic [DW-1:0] d, logic first);
		in_valid <= 1'b1;
		distance <= d;
		first_of_scan <= first;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic sender_gap(int unsigned n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// stop offering and wait for every queued point
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// mostly inside the window, some on its edges, some anywhere
	function automatic logic [DW-1:0] pick_distance(logic [DW-1:0] lo, logic [DW-1:0] hi);
		logic [DW-1:0] d;
		int unsigned roll;
		roll = $urandom_range(0, 19);
		d = $urandom;
		if (roll < 12 && lo + 1 < hi) begin
			d = $urandom_range(lo + 1, hi - 1);
		end else if (roll < 16) begin
			case ($urandom_range(0, 5))
				0: d = lo;
				1: d = lo + 1;
				2: d = hi - 1;
				3: d = hi;
				4: d = '0;
				default: d = DIST_MAX;
			endcase
		end
		return d;
	endfunction

	initial begin
		int unsigned sent, scan_len;
		logic [ANGLE_W-1:0] a0, a1;
		logic [DW-1:0] lo, hi;
		logic [3:0] up0, up1;
		logic first;
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sixteenth-turn steps over every quadrant and octant edge, gate edges
		write_regs('0, 20'd4096, '0, DIST_MAX);
		for (int j = 0; j < 16; j++)
			send_beam(DIST_MAX - 1, j == 0);
		send_beam(20'd1, 1'b0);
		send_beam('0, 1'b0);
		send_beam(DIST_MAX, 1'b0);
		wait_drained();

		// window too narrow to pass anything
		write_regs(20'hF8000, 20'h07FFF, 20'd1000, 20'd1001);
		send_beam(20'd1000, 1'b1);
		send_beam(20'd1001, 1'b0);
		send_beam(20'd1002, 1'b0);
		wait_drained();

		// inverted window at the register extremes
		write_regs(20'h07FFF, 20'hA8000, DIST_MAX, '0);
		send_beam(DIST_MAX, 1'b1);
		send_beam('0, 1'b0);
		wait_drained();

		// random scans, one register setting per phase
		for (int k = 0; k < PHASES; k++) begin
			a0 = $urandom;
			a1 = $urandom;
			lo = $urandom_range(0, 8191);
			hi = $urandom_range(20'h80000, DIST_MAX);
			up0 = $urandom;
			up1 = $urandom;
			case (k)
				0: begin
					a0 = 16'h8000;
					a1 = 16'h7FFF;
					lo = '0;
					hi = DIST_MAX;
				end
				1: begin
					a0 = 16'h7FFF;
					a1 = 16'h8000;
				end
				2: a1 = $urandom_range(1, 64);
				3: begin
					lo = $urandom;
					hi = $urandom;
				end
				5: a1 = -$urandom_range(1, 64);
				7: a1 = '0;
				default: ;
			endcase
			tx_idle_on = (k < PHASES - 2) && (k != 6);
			rx_idle_on = tx_idle_on;
			write_regs({up0, a0}, {up1, a1}, lo, hi);
			// receiver holds off while the sender keeps offering
			if (k == 2)
				rx_hold_req = 1'b1;
			sent = 0;
			while (sent < PER_PHASE) begin
				scan_len = $urandom_range(1, 40);
				for (int j = 0; j < scan_len && sent < PER_PHASE; j++) begin
					first = (j == 0);
					if ($urandom_range(0, 9) == 0)
						first = $urandom_range(0, 1);
					send_beam(pick_distance(lo, hi), first);
					sent++;
					if (tx_idle_on && $urandom_range(0, 7) == 0)
						sender_gap($urandom_range(1, 5));
					// sender pauses until the pipe is empty
					if (k == 4 && sent == PER_PHASE / 2)
						wait_drained();
				end
			end
			wait_drained();
		end

		repeat (40) @(posedge clk);
		if (sb.failures == 0 && sb.pending() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// run limit
	initial begin
		#4000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
